### rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

    // Input kind codes as they arrive on the kind port.
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Classified command carried through the queue.
    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_NONE  = 3'd0;
    localparam cmd_t CMD_START = 3'd1;
    localparam cmd_t CMD_STOP  = 3'd2;
    localparam cmd_t CMD_WRITE = 3'd3;
    localparam cmd_t CMD_READ  = 3'd4;

    localparam int FIFO_DEPTH = 2;

    localparam logic [15:0] TICKS_RESET = 16'd8;

    // Bus levels.
    localparam logic IIC_ACK  = 1'b0;
    localparam logic IIC_NACK = 1'b1;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] write_data;
        logic       send_nack;
        logic       scl_level;
        logic       sda_level;
    } item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

### rtl/i2cm_front.sv
// Front end: accepts input items and classifies their command kind.
module i2cm_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          kind,
    input  logic [7:0]          write_data,
    input  logic                send_nack,
    input  logic                scl_level,
    input  logic                sda_level,
    input  i2cm_pkg::fifo_stat_t stat,
    output logic                push,
    output i2cm_pkg::item_t     item
);

    i2cm_pkg::cmd_t cmd;

    // Unused kind codes behave as a plain tick.
    always_comb
    begin
        case (kind)
            i2cm_pkg::KIND_START: cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::KIND_STOP:  cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::KIND_WRITE: cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::KIND_READ:  cmd = i2cm_pkg::CMD_READ;
            default:              cmd = i2cm_pkg::CMD_NONE;
        endcase
    end

    assign in_ready        = !stat.full;
    assign push            = in_valid && !stat.full;
    assign item.cmd        = cmd;
    assign item.write_data = write_data;
    assign item.send_nack  = send_nack;
    assign item.scl_level  = scl_level;
    assign item.sda_level  = sda_level;

endmodule

### rtl/i2cm_fifo.sv
// Short item queue between the front end and the bit engine.
module i2cm_fifo #(
    parameter int Depth = i2cm_pkg::FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i2cm_pkg::item_t      push_item,
    input  logic                 pop,
    output i2cm_pkg::item_t      pop_item,
    output i2cm_pkg::fifo_stat_t stat
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    i2cm_pkg::item_t mem_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (count_reg == CW'(Depth));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/i2cm_engine.sv
// Back end: bit-timing state machine that steps once per queued item.
module i2cm_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [15:0]     cfg_wr_data,
    input  i2cm_pkg::item_t item,
    input  logic            item_avail,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            scl_release,
    output logic            sda_release,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_data,
    output logic            ack_seen
);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_A    = 5'd1;
    localparam logic [4:0] PH_ST_B    = 5'd2;
    localparam logic [4:0] PH_ST_C    = 5'd3;
    localparam logic [4:0] PH_ST_D    = 5'd4;
    localparam logic [4:0] PH_SP_A    = 5'd5;
    localparam logic [4:0] PH_SP_B    = 5'd6;
    localparam logic [4:0] PH_SP_C    = 5'd7;
    localparam logic [4:0] PH_SP_D    = 5'd8;
    localparam logic [4:0] PH_WR_DATA = 5'd9;
    localparam logic [4:0] PH_WR_HIGH = 5'd10;
    localparam logic [4:0] PH_WR_LOW  = 5'd11;
    localparam logic [4:0] PH_WR_ACK  = 5'd12;
    localparam logic [4:0] PH_RD_HIGH = 5'd13;
    localparam logic [4:0] PH_RD_WAIT = 5'd14;
    localparam logic [4:0] PH_RD_HOLD = 5'd15;
    localparam logic [4:0] PH_RD_LOW  = 5'd16;
    localparam logic [4:0] PH_RD_ACKD = 5'd17;
    localparam logic [4:0] PH_RD_ACKH = 5'd18;

    logic [15:0] ticks_reg, ticks_next;
    logic [4:0]  phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [3:0]  units_reg, units_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        nack_reg, nack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        last_ack_reg, last_ack_next;
    logic        out_valid_reg, out_valid_next;
    logic        step;
    logic        enter;
    logic [4:0]  target;
    logic        done;
    logic        expired;

    // Step when an item is queued and the result register is free or draining.
    assign step = item_avail && (!out_valid_reg || out_ready);
    assign pop  = step;

    // A zero delay unit counts as one tick.
    assign ticks_next = cfg_wr_en ? ((cfg_wr_data == '0) ? 16'd1 : cfg_wr_data) : ticks_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        delay_next     = delay_reg;
        units_next     = units_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        nack_next      = nack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        last_read_next = last_read_reg;
        last_ack_next  = last_ack_reg;
        enter          = 1'b0;
        target         = PH_IDLE;
        done           = 1'b0;
        expired        = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                bit_next = '0;
                case (item.cmd)
                    i2cm_pkg::CMD_START:
                    begin
                        enter  = 1'b1;
                        target = PH_ST_A;
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        enter  = 1'b1;
                        target = PH_SP_A;
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        shift_next = item.write_data;
                        enter      = 1'b1;
                        target     = PH_WR_DATA;
                    end
                    i2cm_pkg::CMD_READ:
                    begin
                        shift_next = '0;
                        nack_next  = item.send_nack;
                        enter      = 1'b1;
                        target     = PH_RD_HIGH;
                    end
                    default:
                    begin
                        enter = 1'b0;
                    end
                endcase
            end
            else if (phase_reg == PH_RD_WAIT)
            begin
                // The slave holds SCL low until it is ready.
                if (item.scl_level)
                begin
                    enter  = 1'b1;
                    target = PH_RD_HOLD;
                end
            end
            else if (phase_reg > PH_RD_ACKH)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                if (delay_reg > 16'd1)
                begin
                    delay_next = delay_reg - 1'b1;
                end
                else if (units_reg > 4'd1)
                begin
                    units_next = units_reg - 1'b1;
                    delay_next = ticks_reg;
                end
                else
                begin
                    expired = 1'b1;
                end

                if (expired)
                begin
                    case (phase_reg)
                        PH_ST_A:    begin enter = 1'b1; target = PH_ST_B; end
                        PH_ST_B:    begin enter = 1'b1; target = PH_ST_C; end
                        PH_ST_C:    begin enter = 1'b1; target = PH_ST_D; end
                        PH_SP_A:    begin enter = 1'b1; target = PH_SP_B; end
                        PH_SP_B:    begin enter = 1'b1; target = PH_SP_C; end
                        PH_SP_C:    begin enter = 1'b1; target = PH_SP_D; end
                        PH_ST_D, PH_SP_D:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_WR_DATA: begin enter = 1'b1; target = PH_WR_HIGH; end
                        PH_WR_HIGH: begin enter = 1'b1; target = PH_WR_LOW; end
                        PH_WR_LOW:
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 1'b1;
                            enter      = 1'b1;
                            target     = (bit_next >= 4'd8) ? PH_WR_ACK : PH_WR_DATA;
                        end
                        PH_WR_ACK:
                        begin
                            last_ack_next = item.sda_level;
                            scl_next      = 1'b0;
                            phase_next    = PH_IDLE;
                            done          = 1'b1;
                        end
                        PH_RD_HIGH:
                        begin
                            enter  = 1'b1;
                            target = item.scl_level ? PH_RD_HOLD : PH_RD_WAIT;
                        end
                        PH_RD_HOLD:
                        begin
                            shift_next = {shift_reg[6:0], item.sda_level};
                            enter      = 1'b1;
                            target     = PH_RD_LOW;
                        end
                        PH_RD_LOW:
                        begin
                            bit_next = bit_reg + 1'b1;
                            enter    = 1'b1;
                            target   = (bit_next >= 4'd8) ? PH_RD_ACKD : PH_RD_HIGH;
                        end
                        PH_RD_ACKD: begin enter = 1'b1; target = PH_RD_ACKH; end
                        PH_RD_ACKH:
                        begin
                            scl_next       = 1'b0;
                            sda_next       = 1'b1;
                            last_read_next = shift_reg;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end

            // Entry actions of the new phase: line changes and timer load.
            if (enter)
            begin
                phase_next = target;
                case (target)
                    PH_ST_A:
                    begin
                        sda_next = 1'b1; units_next = 4'd1; delay_next = ticks_reg;
                    end
                    PH_ST_B:
                    begin
                        scl_next = 1'b1; units_next = 4'd1; delay_next = ticks_reg;
                    end
                    PH_ST_C:
                    begin
                        sda_next = 1'b0; units_next = 4'd10; delay_next = ticks_reg;
                    end
                    PH_ST_D:
                    begin
                        scl_next = 1'b0; units_next = 4'd10; delay_next = ticks_reg;
                    end
                    PH_SP_A:
                    begin
                        sda_next = 1'b0; units_next = 4'd1; delay_next = ticks_reg;
                    end
                    PH_SP_B:
                    begin
                        scl_next = 1'b0; units_next = 4'd1; delay_next = ticks_reg;
                    end
                    PH_SP_C:
                    begin
                        scl_next = 1'b1; units_next = 4'd10; delay_next = ticks_reg;
                    end
                    PH_SP_D:
                    begin
                        sda_next = 1'b1; units_next = 4'd10; delay_next = ticks_reg;
                    end
                    PH_WR_DATA:
                    begin
                        sda_next   = shift_next[7];
                        units_next = 4'd1;
                        delay_next = ticks_reg;
                    end
                    PH_WR_HIGH:
                    begin
                        scl_next = 1'b1; units_next = 4'd5; delay_next = ticks_reg;
                    end
                    PH_WR_LOW:
                    begin
                        scl_next = 1'b0; units_next = 4'd1; delay_next = ticks_reg;
                    end
                    PH_WR_ACK, PH_RD_HIGH:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        units_next = 4'd1;
                        delay_next = ticks_reg;
                    end
                    PH_RD_WAIT:
                    begin
                        units_next = units_reg;
                    end
                    PH_RD_HOLD:
                    begin
                        units_next = 4'd3; delay_next = ticks_reg;
                    end
                    PH_RD_LOW:
                    begin
                        scl_next = 1'b0; units_next = 4'd1; delay_next = ticks_reg;
                    end
                    PH_RD_ACKD:
                    begin
                        sda_next   = nack_reg ? i2cm_pkg::IIC_NACK : i2cm_pkg::IIC_ACK;
                        units_next = 4'd1;
                        delay_next = ticks_reg;
                    end
                    PH_RD_ACKH:
                    begin
                        scl_next = 1'b1; units_next = 4'd5; delay_next = ticks_reg;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= i2cm_pkg::TICKS_RESET;
            phase_reg     <= PH_IDLE;
            delay_reg     <= '0;
            units_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            last_read_reg <= '0;
            last_ack_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ticks_reg     <= ticks_next;
            phase_reg     <= phase_next;
            delay_reg     <= delay_next;
            units_reg     <= units_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            last_read_reg <= last_read_next;
            last_ack_reg  <= last_ack_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register; loaded on every step.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            scl_release <= scl_next;
            sda_release <= sda_next;
            busy_res    <= (phase_next != PH_IDLE);
            done_res    <= done;
            read_data   <= last_read_next;
            ack_seen    <= last_ack_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/i2c_master_byte_engine.sv
// An accepted item is registered first in the queue, then in the engine's result register.
// Throughput: one item per cycle; the engine steps once per item whenever the result
// register is empty or being taken, and the two-entry queue holds items while it stalls.
// Reset (rst_n, asynchronous, active low): engine idle, internal line state released
// (result outputs not reset), queue empty, no result pending, delay unit register 8 ticks.
// Top level: front end, item queue and bit-timing engine of the I2C master.
module i2c_master_byte_engine #(
    parameter int FifoDepth = i2cm_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  write_data,
    input  logic        send_nack,
    input  logic        scl_level,
    input  logic        sda_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_release,
    output logic        sda_release,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_seen
);

    i2cm_pkg::fifo_stat_t stat;
    i2cm_pkg::item_t      push_item;
    i2cm_pkg::item_t      pop_item;
    logic                 push;
    logic                 pop;

    // The front end turns the raw kind code into a command and queues every
    // item, including plain ticks, since each one advances the bit timing.
    i2cm_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .write_data (write_data),
        .send_nack  (send_nack),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .stat       (stat),
        .push       (push),
        .item       (push_item)
    );

    // The queue lets the input side keep flowing while the result side stalls.
    i2cm_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (stat)
    );

    // The engine runs the start, stop, write and read sequences, one tick per
    // item, and registers the line drive and status after each step.
    i2cm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (pop_item),
        .item_avail  (!stat.empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_release (scl_release),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_data   (read_data),
        .ack_seen    (ack_seen)
    );

endmodule
